/* rtl/core/vlpc_pkg.sv */
package vlpc_pkg;

  localparam int VALUE_BITS_DEFAULT = 64;

  // queue between the classifying front and the serializing back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int             SHORT_MAX     = 8;
  localparam logic [3:0]     LONG_COUNT    = 4'd10;
  localparam logic [7:0]     LONG_PREFIX0  = 8'h00;
  localparam logic [7:0]     LONG_PREFIX1  = 8'h40;
  localparam logic [15:0]    LEN_SAT       = 16'hFFFF;
  localparam logic [7:0]     ZERO_BYTE     = 8'h00;
  localparam logic [15:0]    ZERO_RUN_BYTES = 16'd7;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ZEROS,
    PH_READ
  } phase_t;

  typedef enum logic {
    ENT_BYTES,
    ENT_SINGLE
  } entry_kind_t;

  // ENT_BYTES: data holds the coded bytes, first byte in the top 8 bits.
  // ENT_SINGLE: data[63:0] holds the decoded number.
  typedef struct packed {
    entry_kind_t kind;
    logic [79:0] data;
    logic [3:0]  count;
    logic [15:0] length;
    logic        value_valid;
    logic        error;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/core/vlpc_front.sv */
module vlpc_front #(
  parameter int VALUE_BITS = vlpc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [87:0]             s_tdata,
  input  logic                    s_tuser,
  input  vlpc_pkg::queue_status_t q_stat,
  output logic                    push,
  output vlpc_pkg::entry_t        push_entry
);

  logic        accept;
  logic        mode;
  logic [7:0]  in_byte;
  logic [15:0] room;
  logic [63:0] v;

  vlpc_pkg::phase_t        phase, phase_next;
  logic [15:0]             bytes_left, bytes_left_next;
  logic [VALUE_BITS-1:0]   acc, acc_next;
  logic [15:0]             bytes_consumed, bytes_consumed_next;
  logic [15:0]             latched_room, latched_room_next;

  // encode classification
  logic        enc_found;
  logic [3:0]  enc_len;
  logic [79:0] enc_data;
  logic        enc_err;

  // decode step
  logic        idle;
  logic [15:0] eff_lr, eff_bc, eff_bl;
  logic [VALUE_BITS-1:0] eff_acc;
  logic        over;
  logic [15:0] err_len, bc1;
  logic [2:0]  msb;
  logic [7:0]  low_mask;
  logic [16:0] bl_sum;
  logic [15:0] bl_sat;
  logic        dec_push;
  vlpc_pkg::entry_t dec_entry, enc_entry;

  assign mode    = s_tuser;
  assign v       = 64'(s_tdata[VALUE_BITS-1:0]);
  assign in_byte = s_tdata[71:64];
  assign room    = s_tdata[87:72];

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    enc_found = 1'b0;
    enc_len   = vlpc_pkg::LONG_COUNT;
    enc_data  = {vlpc_pkg::LONG_PREFIX0, vlpc_pkg::LONG_PREFIX1, v};
    for (int l = 1; l <= vlpc_pkg::SHORT_MAX; l++) begin
      if (!enc_found && (v < ((64'd1 << (7 * l)) - 64'd1))) begin
        enc_found = 1'b1;
        enc_len   = 4'(l);
        enc_data  = {((64'd1 << (7 * l)) | v) << (8 * (vlpc_pkg::SHORT_MAX - l)), 16'h0};
      end
    end
  end

  assign enc_err = {12'h0, enc_len} > room;

  always_comb begin
    enc_entry             = '0;
    enc_entry.kind        = enc_err ? vlpc_pkg::ENT_SINGLE : vlpc_pkg::ENT_BYTES;
    enc_entry.data        = enc_err ? 80'h0 : enc_data;
    enc_entry.count       = enc_len;
    enc_entry.length      = enc_err ? 16'h0 : {12'h0, enc_len};
    enc_entry.value_valid = 1'b0;
    enc_entry.error       = enc_err;
  end

  assign idle    = (phase == vlpc_pkg::PH_IDLE);
  assign eff_lr  = idle ? room : latched_room;
  assign eff_bc  = idle ? 16'h0 : bytes_consumed;
  assign eff_bl  = idle ? 16'h0 : bytes_left;
  assign eff_acc = idle ? '0 : acc;
  assign over    = eff_bc >= eff_lr;
  assign err_len = (eff_bc != vlpc_pkg::LEN_SAT) ? eff_bc + 16'd1 : vlpc_pkg::LEN_SAT;
  assign bc1     = eff_bc + 16'd1;

  always_comb begin
    msb = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (in_byte[i]) msb = 3'(i);
    end
  end

  assign low_mask = (8'd1 << msb) - 8'd1;
  // a zero byte adds a full run of seven, otherwise the marker position sets it
  assign bl_sum   = {1'b0, eff_bl} + ((in_byte == vlpc_pkg::ZERO_BYTE) ?
                    {1'b0, vlpc_pkg::ZERO_RUN_BYTES} : 17'(7 - {14'h0, msb}));
  assign bl_sat   = bl_sum[16] ? vlpc_pkg::LEN_SAT : bl_sum[15:0];

  always_comb begin
    phase_next          = idle ? vlpc_pkg::PH_IDLE : phase;
    bytes_left_next     = eff_bl;
    acc_next            = eff_acc;
    bytes_consumed_next = eff_bc;
    latched_room_next   = eff_lr;
    dec_push            = 1'b0;
    dec_entry           = '0;
    dec_entry.kind      = vlpc_pkg::ENT_SINGLE;
    if (over) begin
      dec_push              = 1'b1;
      dec_entry.length      = err_len;
      dec_entry.error       = 1'b1;
      phase_next            = vlpc_pkg::PH_IDLE;
      bytes_left_next       = 16'h0;
      acc_next              = '0;
      bytes_consumed_next   = 16'h0;
    end else begin
      bytes_consumed_next = bc1;
      if (phase == vlpc_pkg::PH_READ) begin
        acc_next        = {eff_acc[VALUE_BITS-9:0], in_byte};
        bytes_left_next = eff_bl - 16'd1;
      end else if (in_byte == vlpc_pkg::ZERO_BYTE) begin
        bytes_left_next = bl_sat;
        phase_next      = vlpc_pkg::PH_ZEROS;
      end else begin
        bytes_left_next = bl_sat;
        acc_next        = VALUE_BITS'(in_byte & low_mask);
        phase_next      = vlpc_pkg::PH_READ;
      end
      if (phase_next == vlpc_pkg::PH_READ && bytes_left_next == 16'h0) begin
        dec_push              = 1'b1;
        dec_entry.data        = {16'h0, 64'(acc_next)};
        dec_entry.value_valid = 1'b1;
        dec_entry.length      = bc1;
        phase_next            = vlpc_pkg::PH_IDLE;
        bytes_left_next       = 16'h0;
        acc_next              = '0;
        bytes_consumed_next   = 16'h0;
      end
    end
  end

  assign push       = accept && (!mode || dec_push);
  assign push_entry = mode ? dec_entry : enc_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= vlpc_pkg::PH_IDLE;
      bytes_left     <= 16'h0;
      acc            <= '0;
      bytes_consumed <= 16'h0;
      latched_room   <= 16'h0;
    end else if (accept && mode) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      acc            <= acc_next;
      bytes_consumed <= bytes_consumed_next;
      latched_room   <= latched_room_next;
    end
  end

endmodule

/* rtl/core/vlpc_fifo.sv */
module vlpc_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  vlpc_pkg::entry_t        push_entry,
  input  logic                    pop,
  output vlpc_pkg::entry_t        head,
  output vlpc_pkg::queue_status_t q_stat
);

  vlpc_pkg::entry_t mem [vlpc_pkg::QUEUE_DEPTH];
  logic [vlpc_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [vlpc_pkg::QUEUE_AW:0]   fill;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (fill == (vlpc_pkg::QUEUE_AW + 1)'(vlpc_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/vlpc_back.sv */
module vlpc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  vlpc_pkg::entry_t        head,
  input  vlpc_pkg::queue_status_t q_stat,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [87:0]             m_tdata,
  output logic [2:0]              m_tuser,
  output logic                    m_tlast
);

  logic        advance;
  logic [79:0] sr;
  logic [3:0]  rem;
  logic [15:0] cur_len;

  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [63:0] decoded_value;
  logic        value_valid;
  logic [15:0] length;
  logic        error;

  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && (rem == 4'd0) && !q_stat.empty;

  assign m_tdata = {length, decoded_value, out_byte};
  assign m_tuser = {error, value_valid, byte_valid};
  assign m_tlast = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      rem      <= 4'd0;
    end else if (advance) begin
      if (rem != 4'd0) begin
        // still draining the bytes of an encoded number
        m_tvalid      <= 1'b1;
        out_byte      <= sr[79:72];
        sr            <= sr << 8;
        rem           <= rem - 4'd1;
        last          <= (rem == 4'd1);
        byte_valid    <= 1'b1;
        decoded_value <= 64'h0;
        value_valid   <= 1'b0;
        length        <= cur_len;
        error         <= 1'b0;
      end else if (!q_stat.empty) begin
        m_tvalid <= 1'b1;
        if (head.kind == vlpc_pkg::ENT_SINGLE) begin
          out_byte      <= 8'h0;
          byte_valid    <= 1'b0;
          last          <= 1'b1;
          decoded_value <= head.data[63:0];
          value_valid   <= head.value_valid;
          length        <= head.length;
          error         <= head.error;
        end else begin
          out_byte      <= head.data[79:72];
          sr            <= head.data << 8;
          rem           <= head.count - 4'd1;
          cur_len       <= head.length;
          byte_valid    <= 1'b1;
          last          <= (head.count == 4'd1);
          decoded_value <= 64'h0;
          value_valid   <= 1'b0;
          length        <= head.length;
          error         <= 1'b0;
        end
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/varint_length_prefix_codec.sv */
// Variable-length integer codec (EBML-style length prefix). Each input
// transaction is either an encode (tuser = 0: the value is written as 1 to 8
// marker-prefixed bytes, or as the 10-byte form 0x00 0x40 + 8 value bytes, or
// as a single error result if the length exceeds room) or a decode of one
// coded byte (tuser = 1: a result only when a number completes or the room
// latched at its first byte is exceeded). Input is taken in the same cycle
// whenever the 4-entry result queue has space, so decode runs at one byte per
// cycle. The output serializer sends an encoded number byte by byte (1 to 10
// bytes, tlast on the last), a single result alone with tlast set; it holds
// while m_tready is low, and input stalls only once the queue is full, as
// behind long encodes. No initialization pass is needed after reset.
module varint_length_prefix_codec #(
  parameter int VALUE_BITS = vlpc_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // value[63:0], in_byte[71:64], room[87:72]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // out_byte[7:0], decoded_value[71:8], length[87:72]
  output logic [2:0]  m_tuser,   // byte_valid[0], value_valid[1], error[2]
  output logic        m_tlast    // last
);

  logic                    q_push;
  logic                    q_pop;
  vlpc_pkg::entry_t        q_in;
  vlpc_pkg::entry_t        q_head;
  vlpc_pkg::queue_status_t q_stat;

  vlpc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (q_in)
  );

  vlpc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .q_stat     (q_stat)
  );

  vlpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_bytes_continue: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[0] && !m_tlast) |=> (m_tvalid && m_tuser[0]))
    else $error("encoded number cut short");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("non-byte result without last");

  a_decode_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[87:72] != 16'h0 && !m_tuser[2]))
    else $error("decoded number with bad length or error");

endmodule

/* sim/varint_length_prefix_codec_tb.sv */
`timescale 1ns / 1ps

module varint_length_prefix_codec_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 140;
  localparam int CALM_TAIL     = 40;
  localparam int SETTLE_CYCLES = 40;
  localparam int ZERO_RUN      = 11;      // ends on the room check
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } codec_mode_t;

  typedef struct packed {
    codec_mode_t mode;
    logic [63:0] value;
    logic [7:0]  in_byte;
    logic [15:0] room;
    logic        drain;    // hold off until all results are back
    logic        steady;   // no idle cycles in front of this one
  } codec_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [63:0] decoded_value;
    logic        value_valid;
    logic [15:0] length;
    logic        error;
  } codec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  varint_length_prefix_codec dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  codec_item_t   stim_items[$];
  codec_result_t coded_results[$];
  codec_item_t   head_item;
  codec_result_t got_result;
  codec_result_t want_result;

  // decoder shadow state
  vlpc_pkg::phase_t dec_phase;
  int unsigned      dec_left;
  int unsigned      dec_count;
  int unsigned      dec_room;
  logic [63:0]      dec_acc;

  logic pause_next = 1'b0;
  logic steady_next = 1'b0;
  logic calm = 1'b0;
  int   outstanding = 0;
  int   send_gap = 0;
  int   ready_gap = 0;
  int   cycles = 0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   encodes_taken = 0;
  int   decodes_taken = 0;
  int   values_seen = 0;
  int   errors_seen = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Coded form of v, first byte in bits [79:72]; returns the byte count.
  function automatic int varint_bytes(input logic [63:0] v, output logic [79:0] coded);
    int len;
    logic [63:0] word;
    len = 9;
    for (int l = 8; l >= 1; l--) begin
      if (v < (64'd1 << (7 * l)) - 64'd1) len = l;
    end
    coded = '0;
    if (len <= vlpc_pkg::SHORT_MAX) begin
      word = (64'd1 << (7 * len)) | v;
      coded[79:16] = word << (8 * (8 - len));
      return len;
    end
    coded = {vlpc_pkg::LONG_PREFIX0, vlpc_pkg::LONG_PREFIX1, v};
    return 10;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic bv, input logic lst,
                             input logic [63:0] dv, input logic vv,
                             input logic [15:0] len, input logic err);
    codec_result_t r;
    r.out_byte      = b;
    r.byte_valid    = bv;
    r.last          = lst;
    r.decoded_value = dv;
    r.value_valid   = vv;
    r.length        = len;
    r.error         = err;
    coded_results.push_back(r);
  endtask

  task automatic clear_decoder();
    dec_phase = vlpc_pkg::PH_IDLE;
    dec_left  = 0;
    dec_count = 0;
    dec_acc   = '0;
  endtask

  task automatic compute_codec_results(input logic mode, input logic [63:0] v,
                                       input logic [7:0] b, input logic [15:0] room);
    logic [79:0] coded;
    int n;
    int f;
    if (mode == MODE_ENCODE) begin
      n = varint_bytes(v, coded);
      if (n > room) begin
        push_result(8'h00, 1'b0, 1'b1, '0, 1'b0, 16'd0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++)
          push_result(coded[79 - 8 * i -: 8], 1'b1, i == n - 1, '0, 1'b0, 16'(n), 1'b0);
      end
    end else begin
      if (dec_phase == vlpc_pkg::PH_IDLE) begin
        clear_decoder();
        dec_room = room;
      end
      if (dec_count >= dec_room) begin
        push_result(8'h00, 1'b0, 1'b1, '0, 1'b0,
                    16'(dec_count < vlpc_pkg::LEN_SAT ? dec_count + 1 : vlpc_pkg::LEN_SAT),
                    1'b1);
        clear_decoder();
      end else begin
        dec_count++;
        if (dec_phase == vlpc_pkg::PH_READ) begin
          dec_acc = {dec_acc[55:0], b};
          dec_left--;
        end else if (b == vlpc_pkg::ZERO_BYTE) begin
          dec_left = (dec_left + vlpc_pkg::ZERO_RUN_BYTES > vlpc_pkg::LEN_SAT) ?
                     vlpc_pkg::LEN_SAT : dec_left + vlpc_pkg::ZERO_RUN_BYTES;
          dec_phase = vlpc_pkg::PH_ZEROS;
        end else begin
          f = 7;
          while (f > 0 && !b[f]) f--;
          dec_left = dec_left + 7 - f;
          if (dec_left > vlpc_pkg::LEN_SAT) dec_left = vlpc_pkg::LEN_SAT;
          dec_acc = '0;
          dec_acc[7:0] = b & ((8'd1 << f) - 8'd1);
          dec_phase = vlpc_pkg::PH_READ;
        end
        // a zero byte leaves the count open, so it never completes here
        if (dec_phase == vlpc_pkg::PH_READ && dec_left == 0) begin
          push_result(8'h00, 1'b0, 1'b1, dec_acc, 1'b1, 16'(dec_count), 1'b0);
          clear_decoder();
        end
      end
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly random widths, some values right at a length boundary.
  function automatic logic [63:0] pick_value();
    int bits;
    logic [63:0] v;
    if ($urandom_range(0, 3) == 0) begin
      bits = 7 * $urandom_range(1, 8);
      v = (64'd1 << bits) - 64'd1;
      return v - 64'd1 + $urandom_range(0, 2);
    end
    bits = $urandom_range(0, 64);
    v = rand64();
    if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
    return v;
  endfunction

  function automatic logic [15:0] pick_room();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 11));
    return 16'($urandom_range(10, 65535));
  endfunction

  task automatic add_item(input codec_mode_t mode, input logic [63:0] v,
                          input logic [7:0] b, input logic [15:0] room);
    codec_item_t it;
    it.mode    = mode;
    it.value   = v;
    it.in_byte = b;
    it.room    = room;
    it.drain   = pause_next;
    it.steady  = steady_next;
    pause_next = 1'b0;
    stim_items.push_back(it);
  endtask

  task automatic add_encode(input logic [63:0] v, input logic [15:0] room);
    add_item(MODE_ENCODE, v, 8'($urandom_range(0, 255)), room);
  endtask

  task automatic add_decode(input logic [7:0] b, input logic [15:0] room);
    add_item(MODE_DECODE, rand64(), b, room);
  endtask

  // Feed the coded bytes of v; room only matters on the first byte.
  // With mix set an encode transaction lands right after the first byte.
  task automatic add_coded_number(input logic [63:0] v, input logic [15:0] room,
                                  input logic mix);
    logic [79:0] coded;
    int n;
    n = varint_bytes(v, coded);
    for (int i = 0; i < n; i++) begin
      add_decode(coded[79 - 8 * i -: 8], i == 0 ? room : 16'($urandom_range(0, 65535)));
      if (mix && i == 0) add_encode(pick_value(), pick_room());
    end
  endtask

  initial begin
    int start;
    int k;

    // directed: length boundaries and the room checks
    add_encode(64'd0, 16'hFFFF);
    add_encode(64'd126, 16'd1);
    add_encode(64'd127, 16'd2);
    add_encode(64'd127, 16'd1);
    add_encode((64'd1 << 56) - 64'd2, 16'd8);
    add_encode((64'd1 << 56) - 64'd1, 16'd10);
    add_encode(64'hFFFF_FFFF_FFFF_FFFF, 16'd9);
    add_encode(64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    add_coded_number(64'd127, 16'd2, 1'b0);
    add_decode(8'hFF, 16'd1);
    add_decode(8'h80, 16'd0);
    // number runs past its room on the second byte
    add_decode(8'h40, 16'd1);
    add_decode(8'h12, 16'd500);
    add_coded_number(64'h1F_2345, 16'd3, 1'b1);
    add_coded_number(64'hFFFF_FFFF_FFFF_FFFF, 16'd10, 1'b0);

    // zero run that hits the room limit on its last byte
    pause_next  = 1'b1;
    steady_next = 1'b1;
    for (int i = 0; i < ZERO_RUN; i++) add_decode(vlpc_pkg::ZERO_BYTE, 16'd10);
    steady_next = 1'b0;

    pause_next = 1'b1;
    start = stim_items.size();
    k = 0;
    while (stim_items.size() - start < RANDOM_ITEMS) begin
      if (k % 60 == 59) pause_next = 1'b1;
      k++;
      case ($urandom_range(0, 9))
        0, 1, 2: add_encode(pick_value(), pick_room());
        3, 4, 5, 6: add_coded_number(pick_value(), pick_room(), 1'b0);
        7: add_coded_number(pick_value(), pick_room(), 1'b1);
        8: begin
          repeat ($urandom_range(1, 3))
            add_decode(8'($urandom_range(0, 255)), 16'($urandom_range(0, 15)));
        end
        default: begin
          repeat ($urandom_range(1, 3)) add_decode(vlpc_pkg::ZERO_BYTE, pick_room());
          repeat ($urandom_range(1, 4)) add_decode(8'($urandom_range(0, 255)), pick_room());
        end
      endcase
    end

    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (stim_items.size() != 0 || s_tvalid) @(posedge clk);
    while (coded_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (coded_results.size() != 0)
      $display("%0d expected results never arrived", coded_results.size());
    $display("covered %0d encode and %0d decode transactions, %0d results checked",
             encodes_taken, decodes_taken, results_seen);
    $display("decoded numbers: %0d, room errors: %0d, one %0d-byte zero run",
             values_seen, errors_seen, ZERO_RUN);
    if (mismatches == 0 && coded_results.size() == 0) begin
      $display("varint_length_prefix_codec_tb passed");
    end else begin
      $display("varint_length_prefix_codec_tb failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) void'(stim_items.pop_front());
      if (!(s_tvalid && !s_tready)) begin
        if (stim_items.size() != 0) head_item = stim_items[0];
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (stim_items.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (head_item.drain && (s_tvalid || outstanding != 0)) begin
          s_tvalid <= 1'b0;
        end else if (!calm && !head_item.steady && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 6);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tuser  <= head_item.mode;
          s_tdata  <= {head_item.room, head_item.in_byte, head_item.value};
        end
      end
      calm <= stim_items.size() <= CALM_TAIL;
    end
  end

  // monitor: predicts accepted input, then checks accepted output
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      clear_decoder();
      dec_room = 0;
      coded_results.delete();
      outstanding <= 0;
      ready_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_ENCODE) encodes_taken++;
        else decodes_taken++;
        compute_codec_results(s_tuser, s_tdata[63:0], s_tdata[71:64], s_tdata[87:72]);
      end
      if (m_tvalid && m_tready) begin
        got_result.out_byte      = m_tdata[7:0];
        got_result.byte_valid    = m_tuser[0];
        got_result.last          = m_tlast;
        got_result.decoded_value = m_tdata[71:8];
        got_result.value_valid   = m_tuser[1];
        got_result.length        = m_tdata[87:72];
        got_result.error         = m_tuser[2];
        results_seen++;
        if (got_result.value_valid) values_seen++;
        if (got_result.error) errors_seen++;
        if (coded_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: byte %02h bv %0d last %0d value %016h vv %0d %s",
                     got_result.out_byte, got_result.byte_valid, got_result.last,
                     got_result.decoded_value, got_result.value_valid,
                     $sformatf("len %0d err %0d", got_result.length, got_result.error));
        end else begin
          want_result = coded_results.pop_front();
          if (got_result !== want_result) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch at cycle %0d, expected: byte %02h bv %0d last %0d %s",
                       cycles, want_result.out_byte, want_result.byte_valid,
                       want_result.last,
                       $sformatf("value %016h vv %0d len %0d err %0d",
                                 want_result.decoded_value, want_result.value_valid,
                                 want_result.length, want_result.error));
              $display("  actual: byte %02h bv %0d last %0d %s",
                       got_result.out_byte, got_result.byte_valid, got_result.last,
                       $sformatf("value %016h vv %0d len %0d err %0d",
                                 got_result.decoded_value, got_result.value_valid,
                                 got_result.length, got_result.error));
            end
          end
        end
      end
      outstanding <= coded_results.size();

      if (ready_gap > 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("varint_length_prefix_codec_tb failed");
      $finish;
    end
  end

endmodule
